/* rtl/led_dimming_curve_mapper_unit_assert.svh */
// Assertion macros for the LED dimming curve mapper.
`ifndef LED_DIMMING_CURVE_MAPPER_UNIT_ASSERT_SVH
`define LED_DIMMING_CURVE_MAPPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define LDCM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ldcm assertion failed");

`define LDCM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ldcm assertion failed");

`else

`define LDCM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)

`define LDCM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

/* rtl/ldcm_pkg.sv */
`default_nettype none

package ldcm_pkg;

    localparam logic [1:0] MODE_ANALOG     = 2'd0;
    localparam logic [1:0] MODE_PWM        = 2'd1;
    localparam logic [1:0] MODE_HYBRID     = 2'd2;
    localparam logic [1:0] MODE_HYBRID_ALT = 2'd3;

    localparam logic [1:0] CFG_DIM_MODE = 2'd0;
    localparam logic [1:0] CFG_KNEE     = 2'd1;
    localparam logic [1:0] CFG_MIN_ON   = 2'd2;

    typedef struct packed {
        logic valid;
        logic use_quot;
        logic do_floor;
        logic lit;
    } ldcm_ctrl_t;

endpackage

`default_nettype wire

/* rtl/led_dimming_curve_mapper_unit.sv */
// Pipeline: a stage-0 register, the divider's restoring stages and an output register, in that order.
// Throughput: one level per cycle; the divider is FRAC_BITS restoring stages, one per cycle.
// A stalled result holds the whole pipeline; the input stalls only then.
// Reset: asynchronous, active low; empties the pipeline and loads dim_mode = 2,
// knee_level = ONE / 2, min_on_fraction = 0.
`default_nettype none

module led_dimming_curve_mapper_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               level_valid,
    output logic                    level_stall,
    input  wire logic [FRAC_BITS:0] level,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [FRAC_BITS:0]      current_duty,
    output logic [FRAC_BITS:0]      pwm_duty,
    output logic                    light_on,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [FRAC_BITS:0] cfg_data
);

    `include "led_dimming_curve_mapper_unit_assert.svh"

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                   advance;

    logic [1:0]             dim_mode_reg;
    logic [FRAC_BITS:0]     knee_reg;
    logic [FRAC_BITS:0]     min_on_reg;

    logic [FRAC_BITS:0]     lvl;
    logic [FRAC_BITS:0]     knee_sat;
    logic [FRAC_BITS:0]     knee;
    logic [FRAC_BITS:0]     floor_q;

    ldcm_pkg::ldcm_ctrl_t   s0_ctrl_next;
    logic [FRAC_BITS:0]     s0_cur_next;
    logic [FRAC_BITS:0]     s0_pwm_next;
    ldcm_pkg::ldcm_ctrl_t   s0_ctrl_reg;
    logic [FRAC_BITS:0]     s0_num_reg;
    logic [FRAC_BITS:0]     s0_den_reg;
    logic [FRAC_BITS:0]     s0_cur_reg;
    logic [FRAC_BITS:0]     s0_pwm_reg;

    ldcm_pkg::ldcm_ctrl_t   d_ctrl;
    logic [FRAC_BITS-1:0]   d_quot;
    logic [FRAC_BITS:0]     d_cur;
    logic [FRAC_BITS:0]     d_pwm;

    logic [FRAC_BITS:0]     duty;
    logic [FRAC_BITS:0]     pwm_next;
    logic                   lit_next;

    logic                   result_valid_reg;
    logic [FRAC_BITS:0]     current_duty_reg;
    logic [FRAC_BITS:0]     pwm_duty_reg;
    logic                   light_on_reg;

    assign advance     = !(result_valid_reg && result_stall);
    assign level_stall = !advance;
    assign cfg_ready   = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_mode_reg <= ldcm_pkg::MODE_HYBRID;
            knee_reg     <= ONE >> 1;
            min_on_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ldcm_pkg::CFG_DIM_MODE: dim_mode_reg <= cfg_data[1:0];
                ldcm_pkg::CFG_KNEE:     knee_reg     <= cfg_data;
                ldcm_pkg::CFG_MIN_ON:   min_on_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // stage 0: saturation and mode decode
    always_comb
    begin
        lvl      = (level > ONE) ? ONE : level;
        knee_sat = (knee_reg > ONE) ? ONE : knee_reg;
        knee     = (knee_sat == '0) ? {{FRAC_BITS{1'b0}}, 1'b1} : knee_sat;

        s0_ctrl_next.valid    = level_valid;
        s0_ctrl_next.use_quot = 1'b0;
        s0_ctrl_next.do_floor = 1'b0;
        s0_ctrl_next.lit      = 1'b1;
        s0_cur_next           = lvl;
        s0_pwm_next           = ONE;

        if (lvl == '0)
        begin
            s0_ctrl_next.lit = 1'b0;
            s0_cur_next      = '0;
            s0_pwm_next      = '0;
        end
        else if (dim_mode_reg == ldcm_pkg::MODE_ANALOG)
        begin
            s0_cur_next = lvl;
        end
        else if (dim_mode_reg == ldcm_pkg::MODE_PWM)
        begin
            s0_ctrl_next.do_floor = 1'b1;
            s0_cur_next           = ONE;
            s0_pwm_next           = lvl;
        end
        else if (lvl < knee)
        begin
            s0_ctrl_next.use_quot = 1'b1;
            s0_ctrl_next.do_floor = 1'b1;
            s0_cur_next           = knee;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            s0_ctrl_reg <= s0_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_num_reg <= lvl;
            s0_den_reg <= knee;
            s0_cur_reg <= s0_cur_next;
            s0_pwm_reg <= s0_pwm_next;
        end
    end

    ldcm_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_ctrl  (s0_ctrl_reg),
        .in_num   (s0_num_reg),
        .in_den   (s0_den_reg),
        .in_cur   (s0_cur_reg),
        .in_pwm   (s0_pwm_reg),
        .out_ctrl (d_ctrl),
        .out_quot (d_quot),
        .out_cur  (d_cur),
        .out_pwm  (d_pwm)
    );

    // minimum-on snapping
    always_comb
    begin
        floor_q  = (min_on_reg > ONE) ? ONE : min_on_reg;
        duty     = d_ctrl.use_quot ? {1'b0, d_quot} : d_pwm;
        pwm_next = duty;
        lit_next = d_ctrl.lit;
        if (d_ctrl.do_floor)
        begin
            if (floor_q == '0)
            begin
                lit_next = (duty != '0);
            end
            else if (duty >= floor_q)
            begin
                lit_next = 1'b1;
            end
            else if (duty >= (floor_q >> 1))
            begin
                pwm_next = floor_q;
                lit_next = 1'b1;
            end
            else
            begin
                pwm_next = '0;
                lit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= d_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            current_duty_reg <= d_cur;
            pwm_duty_reg     <= pwm_next;
            light_on_reg     <= lit_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign current_duty = current_duty_reg;
    assign pwm_duty     = pwm_duty_reg;
    assign light_on     = light_on_reg;

    `LDCM_ASSERT_IMPLY(a_dark_no_pwm, clk, rst_n, result_valid && !light_on, pwm_duty == '0)
    `LDCM_ASSERT_IMPLY(a_zero_cur_pwm, clk, rst_n, result_valid && ~|current_duty, ~|pwm_duty)
    `LDCM_ASSERT_IMPLY(a_zero_cur_dark, clk, rst_n, result_valid && ~|current_duty, !light_on)
    `LDCM_ASSERT_IMPLY(a_in_range, clk, rst_n, result_valid, pwm_duty <= ONE && current_duty <= ONE)

endmodule

`default_nettype wire

/* rtl/ldcm_div_pipe.sv */
`default_nettype none

module ldcm_div_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire ldcm_pkg::ldcm_ctrl_t   in_ctrl,
    input  wire logic [FRAC_BITS:0]     in_num,
    input  wire logic [FRAC_BITS:0]     in_den,
    input  wire logic [FRAC_BITS:0]     in_cur,
    input  wire logic [FRAC_BITS:0]     in_pwm,
    output ldcm_pkg::ldcm_ctrl_t        out_ctrl,
    output logic [FRAC_BITS-1:0]        out_quot,
    output logic [FRAC_BITS:0]          out_cur,
    output logic [FRAC_BITS:0]          out_pwm
);

    ldcm_pkg::ldcm_ctrl_t       ctrl_reg [FRAC_BITS];
    logic [FRAC_BITS:0]         rem_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0]       low_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0]       quot_reg [FRAC_BITS];
    logic [FRAC_BITS:0]         den_reg  [FRAC_BITS];
    logic [FRAC_BITS:0]         cur_reg  [FRAC_BITS];
    logic [FRAC_BITS:0]         pwm_reg  [FRAC_BITS];

    // one restoring step per stage; numerator is {num, den >> 1}
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_step
        ldcm_pkg::ldcm_ctrl_t   st_ctrl;
        logic [FRAC_BITS:0]     st_rem;
        logic [FRAC_BITS-1:0]   st_low;
        logic [FRAC_BITS-1:0]   st_quot;
        logic [FRAC_BITS:0]     st_den;
        logic [FRAC_BITS:0]     st_cur;
        logic [FRAC_BITS:0]     st_pwm;
        logic [FRAC_BITS+1:0]   shifted;
        logic [FRAC_BITS+1:0]   diff;
        logic                   ge;
        logic [FRAC_BITS:0]     rem_next;
        logic [FRAC_BITS-1:0]   low_next;
        logic [FRAC_BITS-1:0]   quot_next;

        if (i == 0) begin : g_first
            assign st_ctrl = in_ctrl;
            assign st_rem  = in_num;
            assign st_low  = in_den[FRAC_BITS:1];
            assign st_quot = '0;
            assign st_den  = in_den;
            assign st_cur  = in_cur;
            assign st_pwm  = in_pwm;
        end
        else begin : g_next
            assign st_ctrl = ctrl_reg[i-1];
            assign st_rem  = rem_reg[i-1];
            assign st_low  = low_reg[i-1];
            assign st_quot = quot_reg[i-1];
            assign st_den  = den_reg[i-1];
            assign st_cur  = cur_reg[i-1];
            assign st_pwm  = pwm_reg[i-1];
        end

        assign shifted   = {st_rem, st_low[FRAC_BITS-1]};
        assign diff      = shifted - {1'b0, st_den};
        assign ge        = (shifted >= {1'b0, st_den});
        assign rem_next  = ge ? diff[FRAC_BITS:0] : shifted[FRAC_BITS:0];
        assign low_next  = {st_low[FRAC_BITS-2:0], 1'b0};
        assign quot_next = {st_quot[FRAC_BITS-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[i] <= '0;
            end
            else if (advance)
            begin
                ctrl_reg[i] <= st_ctrl;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= low_next;
                quot_reg[i] <= quot_next;
                den_reg[i]  <= st_den;
                cur_reg[i]  <= st_cur;
                pwm_reg[i]  <= st_pwm;
            end
        end
    end

    assign out_ctrl = ctrl_reg[FRAC_BITS-1];
    assign out_quot = quot_reg[FRAC_BITS-1];
    assign out_cur  = cur_reg[FRAC_BITS-1];
    assign out_pwm  = pwm_reg[FRAC_BITS-1];

endmodule

`default_nettype wire

/* tb/led_dimming_curve_mapper_unit_tb.sv */
`timescale 1ns / 100ps

module led_dimming_curve_mapper_unit_tb;

    localparam int FRAC_BITS = 16;
    localparam int DW = FRAC_BITS + 1;
    localparam logic [DW-1:0] ONE_Q = DW'(1 << FRAC_BITS);

    typedef struct packed {
        logic [DW-1:0] current_duty;
        logic [DW-1:0] pwm_duty;
        logic          light_on;
    } dimming_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          level_valid = 1'b0;
    logic          level_stall;
    logic [DW-1:0] level = '0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    logic [DW-1:0] current_duty;
    logic [DW-1:0] pwm_duty;
    logic          light_on;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = ldcm_pkg::CFG_DIM_MODE;
    logic [DW-1:0] cfg_data = '0;

    logic [1:0]    mode_cfg = ldcm_pkg::MODE_HYBRID;
    logic [DW-1:0] knee_cfg = 17'd32768;
    logic [DW-1:0] min_on_cfg = '0;

    dimming_result_t expected_results[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    led_dimming_curve_mapper_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .level_valid(level_valid),
        .level_stall(level_stall),
        .level(level),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .current_duty(current_duty),
        .pwm_duty(pwm_duty),
        .light_on(light_on),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [DW-1:0] saturate_q(input logic [DW-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic logic [DW-1:0] effective_knee();
        logic [DW-1:0] k;
        k = saturate_q(knee_cfg);
        return (k == '0) ? 17'd1 : k;
    endfunction

    // min-on snapping; current_duty left at zero
    function automatic dimming_result_t snap_min_on(input logic [DW-1:0] duty,
                                                    input logic [DW-1:0] floor_q);
        dimming_result_t r;
        r = '0;
        if (floor_q == '0)
        begin
            r.pwm_duty = duty;
            r.light_on = (duty != '0);
        end
        else if (duty >= floor_q)
        begin
            r.pwm_duty = duty;
            r.light_on = 1'b1;
        end
        else if (duty >= (floor_q >> 1))
        begin
            r.pwm_duty = floor_q;
            r.light_on = 1'b1;
        end
        return r;
    endfunction

    function automatic dimming_result_t predict_dimming(input logic [DW-1:0] level_raw);
        logic [DW-1:0] lvl;
        logic [DW-1:0] floor_q;
        logic [DW-1:0] knee;
        logic [63:0]   num;
        logic [63:0]   quot;
        dimming_result_t r;
        lvl = saturate_q(level_raw);
        floor_q = saturate_q(min_on_cfg);
        knee = effective_knee();
        r = '0;
        if (lvl != '0)
        begin
            if (mode_cfg == ldcm_pkg::MODE_ANALOG ||
                (mode_cfg != ldcm_pkg::MODE_PWM && lvl >= knee))
            begin
                r.current_duty = lvl;
                r.pwm_duty = ONE_Q;
                r.light_on = 1'b1;
            end
            else if (mode_cfg == ldcm_pkg::MODE_PWM)
            begin
                r = snap_min_on(lvl, floor_q);
                r.current_duty = ONE_Q;
            end
            else
            begin
                num = (64'(lvl) << FRAC_BITS) + 64'(knee >> 1);
                quot = num / 64'(knee);
                r = snap_min_on(quot[DW-1:0], floor_q);
                r.current_duty = knee;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        dimming_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no level pending");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (current_duty !== want.current_duty)
                begin
                    $error("current_duty: expected %0d, actual %0d",
                           want.current_duty, current_duty);
                    error_count++;
                end
                if (pwm_duty !== want.pwm_duty)
                begin
                    $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, pwm_duty);
                    error_count++;
                end
                if (light_on !== want.light_on)
                begin
                    $error("light_on: expected %0d, actual %0d", want.light_on, light_on);
                    error_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_level(input logic [DW-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            level_valid <= 1'b0;
            @(posedge clk);
        end
        level_valid <= 1'b1;
        level <= value;
        @(posedge clk);
        while (level_stall)
            @(posedge clk);
        expected_results.push_back(predict_dimming(value));
    endtask

    task automatic wait_results_drained();
        level_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; apply_config lowers it once after the last write
    task automatic write_register(input logic [1:0] idx, input logic [DW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ldcm_pkg::CFG_DIM_MODE: mode_cfg = value[1:0];
            ldcm_pkg::CFG_KNEE:     knee_cfg = value;
            ldcm_pkg::CFG_MIN_ON:   min_on_cfg = value;
            default:                ;
        endcase
    endtask

    task automatic apply_config(input logic [1:0] mode, input logic [DW-1:0] knee,
                                input logic [DW-1:0] floor_q);
        logic [DW-1:0] mode_word;
        mode_word = DW'($urandom_range(131071));
        mode_word[1:0] = mode;
        wait_results_drained();
        write_register(ldcm_pkg::CFG_DIM_MODE, mode_word);
        write_register(ldcm_pkg::CFG_KNEE, knee);
        write_register(ldcm_pkg::CFG_MIN_ON, floor_q);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DW-1:0] random_q();
        case ($urandom_range(7))
            0: return '0;
            1: return 17'd1;
            2: return ONE_Q;
            3: return DW'($urandom_range(131071));
            4: return DW'($urandom_range(131071, 65537));
            5: return DW'($urandom_range(4096));
            default: return DW'($urandom_range(65536));
        endcase
    endfunction

    // aims at the knee, the floor and its half point in level terms, and at the floor in duty terms
    function automatic logic [DW-1:0] random_level();
        longint knee_eff;
        longint floor_eff;
        longint target;
        knee_eff = longint'(effective_knee());
        floor_eff = longint'(saturate_q(min_on_cfg));
        case ($urandom_range(9))
            0: target = 0;
            1: target = longint'($urandom_range(131071));
            2: target = knee_eff + int'($urandom_range(6)) - 3;
            3: target = longint'($urandom_range(int'(knee_eff)));
            4: target = floor_eff + int'($urandom_range(4)) - 2;
            5: target = (floor_eff >> 1) + int'($urandom_range(4)) - 2;
            6: target = ((floor_eff * knee_eff) >> FRAC_BITS) + int'($urandom_range(4)) - 2;
            7: target = 65536 + longint'($urandom_range(65535));
            default: target = longint'($urandom_range(65536));
        endcase
        if (target < 0)
            target = 0;
        if (target > 131071)
            target = 131071;
        return DW'(target);
    endfunction

    task automatic test_reset_defaults();
        send_level(17'd0);
        send_level(17'd1);
        send_level(17'd16384);
        send_level(17'd32767);
        send_level(17'd32768);
        send_level(ONE_Q);
        send_level(17'h1FFFF);
    endtask

    task automatic test_analog_mode();
        apply_config(ldcm_pkg::MODE_ANALOG, 17'd32768, 17'd0);
        send_level(17'd0);
        send_level(17'd1);
        send_level(ONE_Q);
        send_level(17'h1FFFF);
    endtask

    task automatic test_pwm_min_on();
        apply_config(ldcm_pkg::MODE_PWM, 17'd32768, 17'd1000);
        send_level(17'd1000);
        send_level(17'd999);
        send_level(17'd500);
        send_level(17'd499);
        send_level(17'd0);
        send_level(ONE_Q);
    endtask

    task automatic test_hybrid_edges();
        apply_config(ldcm_pkg::MODE_HYBRID_ALT, 17'd0, 17'd0);
        send_level(17'd1);
        send_level(17'd0);
        apply_config(ldcm_pkg::MODE_HYBRID, 17'h1FFFF, 17'h1FFFF);
        send_level(17'd65535);
        send_level(17'd32767);
        send_level(17'd32768);
        send_level(ONE_Q);
    endtask

    task automatic test_random_sweep();
        int send_pct[4] = '{0, 72, 0, 31};
        int recv_pct[4] = '{0, 0, 72, 31};
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            for (int k = 0; k < 12; k++)
            begin
                apply_config(2'($urandom_range(3)), random_q(), random_q());
                repeat (40)
                    send_level(random_level());
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_analog_mode();
        test_pwm_min_on();
        test_hybrid_edges();
        test_random_sweep();
        wait_results_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* led_dimming_curve_mapper_unit.f */
+incdir+rtl
rtl/ldcm_pkg.sv
rtl/ldcm_div_pipe.sv
rtl/led_dimming_curve_mapper_unit.sv
tb/led_dimming_curve_mapper_unit_tb.sv
